// File: hw/rtl/averaged_input_change_detector_core_macros.svh
// ----------------------------------------------------------------------------
// averaged input change detector - assertion macros
// shared property forms for the checker files
// ----------------------------------------------------------------------------
`ifndef AVERAGED_INPUT_CHANGE_DETECTOR_CORE_MACROS_SVH
`define AVERAGED_INPUT_CHANGE_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define AICD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define AICD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/aicd_pkg.sv
// ----------------------------------------------------------------------------
// aicd_pkg
// widths, register map and shared types of the averaged input change detector
// ----------------------------------------------------------------------------
package aicd_pkg;

  // field widths
  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 10;
  localparam int SUM_W    = 16;
  localparam int CNT_W    = 6;
  localparam int DEV_W    = 7;
  localparam int DEB_W    = 16;

  // config bus
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  // sample count limits
  localparam int COUNT_MIN   = 2;
  localparam int COUNT_LIMIT = 60;

  // parameter defaults
  localparam int MAX_SAMPLES_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 10;

  // register indexes
  localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COUNT     = 3'd1;
  localparam logic [IDX_W-1:0] REG_BUFFERED  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEVIATION = 3'd3;
  localparam logic [IDX_W-1:0] REG_FIXED     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ANALOG    = 3'd5;
  localparam logic [IDX_W-1:0] REG_INIT_LVL  = 3'd6;

  // ring store control from the sequencer
  typedef struct packed {
    logic clear;
    logic rd_en;
    logic wr_en;
  } ring_ctl_t;

endpackage

// File: hw/rtl/averaged_input_change_detector_core.sv
// ----------------------------------------------------------------------------
// averaged_input_change_detector_core
// Each transfer in is one poll tick (time in ms and a pin sample). A poll is
// used only when at least debounce_ms have passed since the change mark. The
// sample is used directly, summed into a block average, or kept in a ring for
// a running average; the average is compared with the held level through a
// deviation hysteresis and a rising or falling event with the new level is
// sent out. A poll that completes an average waits for the shared divider,
// which produces one quotient bit per cycle over the 16-bit sum, and an
// event also waits while an earlier one is still held by out_ready. The
// block takes one poll at a time and takes none in a cycle with a config
// write. The ring store clears at once through valid bits, so no clearing
// pass follows reset.
// ----------------------------------------------------------------------------
module averaged_input_change_detector_core #(
  parameter int MAX_SAMPLES = aicd_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = aicd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // poll input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aicd_pkg::TIME_W-1:0]   now_ms,
  input  logic [aicd_pkg::SAMPLE_W-1:0] sample,
  // event output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          edge_res,
  output logic [aicd_pkg::LEVEL_W-1:0]  level,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aicd_pkg::ADDR_W-1:0]   paddr,
  input  logic [aicd_pkg::DATA_W-1:0]   pwdata,
  output logic [aicd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AW        = $clog2(MAX_SAMPLES);
  localparam int LW        = aicd_pkg::LEVEL_W;
  localparam int SW        = aicd_pkg::SUM_W;
  localparam int CW        = aicd_pkg::CNT_W;
  localparam int DW        = aicd_pkg::DEV_W;
  localparam int MASK_BITS = (SAMPLE_BITS < LW) ? SAMPLE_BITS : LW;
  localparam logic [LW-1:0] SMASK = LW'((33'd1 << MASK_BITS) - 33'd1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_RREAD = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // config registers
  logic [aicd_pkg::DEB_W-1:0] debounce_ms;
  logic [CW-1:0]              sample_count;
  logic                       buffered_mode;
  logic [DW-1:0]              deviation;
  logic                       fixed_steps;
  logic                       analog_mode;
  logic [LW-1:0]              initial_level;

  // state
  logic [2:0]                  state;
  logic [CW-1:0]               ring_pos;
  logic [SW-1:0]               running_sum;
  logic [LW-1:0]               held_level;
  logic [aicd_pkg::TIME_W-1:0] change_mark;

  // item payload
  logic [aicd_pkg::TIME_W-1:0]   now_r;
  logic [aicd_pkg::SAMPLE_W-1:0] s_r;
  logic [SW-1:0]                 avg_r;
  logic                          res_edge;
  logic [LW-1:0]                 res_level;

  // config write decode
  logic                      cfg_wr;
  logic [aicd_pkg::IDX_W-1:0] cfg_idx;
  logic [CW-1:0]             cnt_wval;
  logic                      cnt_ok;
  logic [DW-1:0]             dev_wval;
  logic                      avg_clear;

  // datapath
  logic [aicd_pkg::SAMPLE_W-1:0] s_in;
  logic [aicd_pkg::TIME_W-1:0]   elapsed;
  logic                          too_soon;
  logic                          ring_mode;
  logic [SW-1:0]                 sum_add;
  logic [CW:0]                   pos_inc;
  logic                          block_end;
  logic [SW-1:0]                 sum_ring;
  logic [LW:0]                   hi_lim;
  logic [LW-1:0]                 lo_lim;
  logic                          rise;
  logic                          fall;
  logic                          fixed;
  logic [LW-1:0]                 new_level;

  aicd_pkg::ring_ctl_t           ring_ctl;
  logic [aicd_pkg::SAMPLE_W-1:0] ring_rd;
  logic                          div_start;
  logic [SW-1:0]                 div_arg;
  logic                          div_done;
  logic [SW-1:0]                 div_quo;

  assign pready   = 1'b1;
  assign in_ready = (state == ST_IDLE) && !cfg_wr;

  // config decode
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];
  assign cnt_wval  = pwdata[CW-1:0];
  assign cnt_ok    = (cnt_wval >= CW'(aicd_pkg::COUNT_MIN)) &&
                     (cnt_wval <= CW'(aicd_pkg::COUNT_LIMIT)) &&
                     ({1'b0, cnt_wval} <= (CW+1)'(MAX_SAMPLES));
  assign dev_wval  = (pwdata[DW-1:0] > DW'(1) && !analog_mode) ? DW'(1) : pwdata[DW-1:0];
  assign avg_clear = cfg_wr && (cfg_idx == aicd_pkg::REG_COUNT ||
                                cfg_idx == aicd_pkg::REG_BUFFERED);

  // config readback
  always_comb begin
    unique case (cfg_idx)
      aicd_pkg::REG_DEBOUNCE:  prdata = 32'(debounce_ms);
      aicd_pkg::REG_COUNT:     prdata = 32'(sample_count);
      aicd_pkg::REG_BUFFERED:  prdata = 32'(buffered_mode);
      aicd_pkg::REG_DEVIATION: prdata = 32'(deviation);
      aicd_pkg::REG_FIXED:     prdata = 32'(fixed_steps);
      aicd_pkg::REG_ANALOG:    prdata = 32'(analog_mode);
      aicd_pkg::REG_INIT_LVL:  prdata = 32'(initial_level);
      default:                 prdata = '0;
    endcase
  end

  // input sample masking and digital folding
  always_comb begin
    s_in = sample & aicd_pkg::SAMPLE_W'(SMASK);
    if (!analog_mode) begin
      s_in = (s_in != '0) ? aicd_pkg::SAMPLE_W'(1) : '0;
    end
  end

  // debounce check and block bookkeeping
  assign elapsed   = now_r - change_mark;
  assign too_soon  = elapsed < aicd_pkg::TIME_W'(debounce_ms);
  assign ring_mode = buffered_mode && (sample_count != '0);
  assign sum_add   = running_sum + SW'(s_r);
  assign pos_inc   = {1'b0, ring_pos} + 1'b1;
  assign block_end = pos_inc >= {1'b0, sample_count};
  assign sum_ring  = running_sum - SW'(ring_rd) + SW'(s_r);

  // hysteresis compare
  assign hi_lim = {1'b0, held_level} + (LW+1)'(deviation);
  assign lo_lim = held_level - LW'(deviation);
  assign rise   = avg_r >= SW'(hi_lim);
  assign fall   = (held_level >= LW'(deviation)) && (avg_r <= SW'(lo_lim));
  assign fixed  = fixed_steps && (deviation != '0);

  always_comb begin
    if (rise) begin
      new_level = fixed ? hi_lim[LW-1:0] : avg_r[LW-1:0];
    end else begin
      new_level = fixed ? lo_lim : avg_r[LW-1:0];
    end
    new_level = new_level & SMASK;
  end

  // ring and divider hookup
  always_comb begin
    ring_ctl.clear = avg_clear;
    ring_ctl.rd_en = (state == ST_CHECK) && !too_soon && ring_mode;
    ring_ctl.wr_en = (state == ST_RREAD);
  end

  assign div_start = ((state == ST_CHECK) && !too_soon && !ring_mode &&
                      (sample_count != '0) && block_end) ||
                     (state == ST_RREAD);
  assign div_arg   = (state == ST_RREAD) ? sum_ring : sum_add;

  aicd_ring #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ring_ctl),
    .addr    (ring_pos[AW-1:0]),
    .wr_data (s_r),
    .rd_data (ring_rd)
  );

  aicd_div #(
    .N (SW),
    .D (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_arg),
    .divisor  (sample_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      debounce_ms   <= '0;
      sample_count  <= '0;
      buffered_mode <= 1'b0;
      deviation     <= DW'(1);
      fixed_steps   <= 1'b0;
      analog_mode   <= 1'b1;
      initial_level <= '0;
      ring_pos      <= '0;
      running_sum   <= '0;
      held_level    <= '0;
      change_mark   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        aicd_pkg::REG_DEBOUNCE:  debounce_ms <= pwdata[aicd_pkg::DEB_W-1:0];
        aicd_pkg::REG_COUNT:     sample_count <= cnt_ok ? cnt_wval : '0;
        aicd_pkg::REG_BUFFERED:  buffered_mode <= pwdata[0];
        aicd_pkg::REG_DEVIATION: deviation <= dev_wval;
        aicd_pkg::REG_FIXED:     fixed_steps <= pwdata[0];
        aicd_pkg::REG_ANALOG:    analog_mode <= pwdata[0];
        aicd_pkg::REG_INIT_LVL: begin
          initial_level <= pwdata[LW-1:0];
          held_level    <= pwdata[LW-1:0] & SMASK;
        end
        default: ;
      endcase
      if (avg_clear) begin
        ring_pos    <= '0;
        running_sum <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (too_soon) begin
            state <= ST_IDLE;
          end else if (ring_mode) begin
            state <= ST_RREAD;
          end else if (sample_count == '0) begin
            state <= ST_CMP;
          end else if (block_end) begin
            running_sum <= '0;
            ring_pos    <= '0;
            state       <= ST_DIV;
          end else begin
            running_sum <= sum_add;
            ring_pos    <= pos_inc[CW-1:0];
            change_mark <= now_r;
            state       <= ST_IDLE;
          end
        end
        ST_RREAD: begin
          change_mark <= now_r;
          running_sum <= sum_ring;
          ring_pos    <= block_end ? '0 : pos_inc[CW-1:0];
          state       <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (rise || fall) begin
            held_level  <= new_level;
            change_mark <= now_r;
            state       <= ST_OUT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r <= now_ms;
      s_r   <= s_in;
    end
    if (state == ST_CHECK) begin
      avg_r <= SW'(s_r);
    end else if (state == ST_DIV && div_done) begin
      avg_r <= div_quo;
    end
    if (state == ST_CMP) begin
      res_edge  <= rise;
      res_level <= new_level;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      edge_res <= res_edge;
      level    <= res_level;
    end
  end

endmodule

// File: hw/rtl/aicd_div.sv
// ----------------------------------------------------------------------------
// aicd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aicd_div #(
  parameter int N = aicd_pkg::SUM_W,
  parameter int D = aicd_pkg::CNT_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [D-1:0]  rem;
  logic [N-1:0]  quo;
  logic [D-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [D:0]    trial;
  logic          fits;

  // trial subtract of the next dividend bit
  assign trial = {rem, quo[N-1]};
  assign fits  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= D'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[D-1:0];
      end
      quo <= {quo[N-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// File: hw/rtl/aicd_ring.sv
// ----------------------------------------------------------------------------
// aicd_ring
// sample ring store with per-entry valid bits, unwritten entries read zero
// ----------------------------------------------------------------------------
module aicd_ring #(
  parameter int DEPTH = aicd_pkg::MAX_SAMPLES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  aicd_pkg::ring_ctl_t           ctl,
  input  logic [AW-1:0]                 addr,
  input  logic [aicd_pkg::SAMPLE_W-1:0] wr_data,
  output logic [aicd_pkg::SAMPLE_W-1:0] rd_data
);

  logic [aicd_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]              valid;
  logic [aicd_pkg::SAMPLE_W-1:0] mem_q;
  logic                          valid_q;

  // valid bits, cleared at once
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[addr] <= 1'b1;
    end
  end

  // memory write
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      mem_q   <= mem[addr];
      valid_q <= valid[addr];
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

// File: hw/rtl/aicd_checker.sv
// ----------------------------------------------------------------------------
// aicd_checker
// port-level checks of the averaged input change detector, bound to the core
// ----------------------------------------------------------------------------
`include "averaged_input_change_detector_core_macros.svh"

module aicd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         edge_res,
  input logic [aicd_pkg::LEVEL_W-1:0] level
);

  // a stalled result transfer holds its payload
  `AICD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(level) && $stable(edge_res), "result changed while stalled")

  // one poll at a time: the block is busy right after taking a poll
  `AICD_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready, "poll taken while busy")

  // no result shows up in the cycle after a poll is taken
  `AICD_ASSERT_NEXT(a_no_early_result, clk, rst, in_valid && in_ready, !$rose(out_valid), "result too early")

  // a new result appears as the block goes back to idle
  `AICD_ASSERT_SAME(a_result_idle, clk, rst, $rose(out_valid), in_ready, "result without idle")

endmodule

bind averaged_input_change_detector_core aicd_checker u_aicd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .edge_res  (edge_res),
  .level     (level)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - averaged input change detector testbench
// Drives poll ticks into the core with random idle gaps and output stalls,
// reprograms the registers between phases over the config bus, predicts the
// rising/falling events and held levels, and checks every event transfer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // address slot past the last register, writes there are dropped
  localparam logic [aicd_pkg::IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_POLLS  = 1030;

  typedef struct packed {
    logic                         edge_res;
    logic [aicd_pkg::LEVEL_W-1:0] level;
  } level_event_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [aicd_pkg::TIME_W-1:0]   now_ms = '0;
  logic [aicd_pkg::SAMPLE_W-1:0] sample = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          edge_res;
  logic [aicd_pkg::LEVEL_W-1:0]  level;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [aicd_pkg::ADDR_W-1:0]   paddr = '0;
  logic [aicd_pkg::DATA_W-1:0]   pwdata = '0;
  logic [aicd_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  averaged_input_change_detector_core dut (.*);

  // tracks registers, averaging state and held level; queues the events due
  class level_tracker;
    logic [aicd_pkg::DEB_W-1:0]    debounce_ms;
    logic [aicd_pkg::CNT_W-1:0]    sample_count;
    logic                          buffered;
    logic [aicd_pkg::DEV_W-1:0]    deviation;
    logic                          fixed_steps;
    logic                          analog;
    logic [aicd_pkg::SAMPLE_W-1:0] ring [aicd_pkg::MAX_SAMPLES_DEF];
    logic [aicd_pkg::CNT_W-1:0]    ring_pos;
    logic [aicd_pkg::SUM_W-1:0]    sum;
    logic [aicd_pkg::LEVEL_W-1:0]  held;
    logic [aicd_pkg::TIME_W-1:0]   mark;
    level_event_t                  expected_events[$];
    int                            mismatches;

    function new();
      debounce_ms  = '0;
      sample_count = '0;
      buffered     = 1'b0;
      deviation    = 7'd1;
      fixed_steps  = 1'b0;
      analog       = 1'b1;
      held         = '0;
      mark         = '0;
      mismatches   = 0;
      clear_avg();
    endfunction

    function void clear_avg();
      foreach (ring[i]) ring[i] = '0;
      ring_pos = '0;
      sum      = '0;
    endfunction

    // register write as the core stores it
    function void write_reg(logic [aicd_pkg::IDX_W-1:0] idx,
                            logic [aicd_pkg::DATA_W-1:0] value);
      logic [15:0] v;
      v = value[15:0];
      case (idx)
        aicd_pkg::REG_DEBOUNCE: debounce_ms = v;
        aicd_pkg::REG_COUNT: begin
          sample_count = (v[5:0] >= aicd_pkg::COUNT_MIN &&
                          v[5:0] <= aicd_pkg::COUNT_LIMIT) ? v[5:0] : '0;
          clear_avg();
        end
        aicd_pkg::REG_BUFFERED: begin
          buffered = v[0];
          clear_avg();
        end
        aicd_pkg::REG_DEVIATION: deviation = (v[6:0] > 1 && !analog) ? 7'd1 : v[6:0];
        aicd_pkg::REG_FIXED: fixed_steps = v[0];
        aicd_pkg::REG_ANALOG: analog = v[0];
        aicd_pkg::REG_INIT_LVL: held = v[9:0];
        default: ;
      endcase
    endfunction

    // one accepted poll tick
    function void take_poll(logic [aicd_pkg::TIME_W-1:0] now,
                            logic [aicd_pkg::SAMPLE_W-1:0] smp);
      logic [aicd_pkg::TIME_W-1:0] elapsed;
      int s, avg, cnt, p;
      bit fixed;
      level_event_t ev;
      s = analog ? int'(smp) : int'(smp != 0);
      elapsed = now - mark;
      if (elapsed < debounce_ms) return;
      cnt = int'(sample_count);
      p = int'(ring_pos);
      if (buffered && cnt != 0) begin
        // running average over the ring
        mark = now;
        sum = aicd_pkg::SUM_W'(int'(sum) - int'(ring[p]) + s);
        ring[p] = aicd_pkg::SAMPLE_W'(s);
        ring_pos = (p + 1 >= cnt) ? '0 : aicd_pkg::CNT_W'(p + 1);
        avg = int'(sum) / cnt;
      end else if (cnt == 0) begin
        avg = s;
      end else begin
        // block average, partial blocks move the mark only
        sum = aicd_pkg::SUM_W'(int'(sum) + s);
        if (p + 1 >= cnt) begin
          avg = int'(sum) / cnt;
          sum = '0;
          ring_pos = '0;
        end else begin
          ring_pos = aicd_pkg::CNT_W'(p + 1);
          mark = now;
          return;
        end
      end
      // hysteresis around the held level
      fixed = fixed_steps && deviation > 0;
      if (avg >= int'(held) + int'(deviation)) begin
        ev.edge_res = 1'b1;
        ev.level = fixed ? aicd_pkg::LEVEL_W'(int'(held) + int'(deviation))
                         : aicd_pkg::LEVEL_W'(avg);
      end else if (held >= deviation && avg <= int'(held) - int'(deviation)) begin
        ev.edge_res = 1'b0;
        ev.level = fixed ? aicd_pkg::LEVEL_W'(int'(held) - int'(deviation))
                         : aicd_pkg::LEVEL_W'(avg);
      end else begin
        return;
      end
      held = ev.level;
      mark = now;
      expected_events.push_back(ev);
    endfunction

    // one accepted event against the oldest one due
    function void check_event(logic e, logic [aicd_pkg::LEVEL_W-1:0] lvl);
      level_event_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: event with none due, edge_res %0b level %0d", $time, e, lvl);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      if (want.edge_res !== e) begin
        $display("%0t: edge_res expected %0b actual %0b", $time, want.edge_res, e);
        mismatches++;
      end
      if (want.level !== lvl) begin
        $display("%0t: level expected %0d actual %0d", $time, want.level, lvl);
        mismatches++;
      end
    endfunction
  endclass

  level_tracker                tracker = new();
  logic [aicd_pkg::TIME_W-1:0] clock_ms = '0;
  int                          src_calm = 0;
  int                          sink_calm = 0;
  int                          quiet_cycles = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // wait length per item, with runs of back-to-back items now and then
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 30) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 10);
  endfunction

  // random bits above the register width, on some writes
  function automatic logic [aicd_pkg::DATA_W-1:0] with_junk(input int unsigned val,
                                                             input int w);
    logic [aicd_pkg::DATA_W-1:0] junk;
    junk = $urandom();
    if ($urandom_range(0, 3) != 0) return val;
    return (junk << w) | val;
  endfunction

  function automatic int clamp_code(input int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // transfer monitor, checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.take_poll(now_ms, sample);
      if (out_valid && out_ready) tracker.check_event(edge_res, level);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // event side with random stalls
  initial begin : event_sink
    int stall;
    forever begin
      stall = pick_gap(sink_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one poll transfer, returns at the accepting edge with valid still high
  task automatic send_poll(input logic [aicd_pkg::TIME_W-1:0] t,
                           input logic [aicd_pkg::SAMPLE_W-1:0] s);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms   <= t;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // config bus write: setup phase, access phase, then idle
  task automatic reg_write(input logic [aicd_pkg::IDX_W-1:0] idx,
                           input logic [aicd_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.write_reg(idx, val);
    @(posedge clk);
  endtask

  // stop polling and let the core go idle
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_setup();
    int unsigned deb, cnt, dev, lvl, r;
    logic ana, analog_first;
    r = $urandom_range(0, 9);
    if (r < 6) deb = 0;
    else if (r < 9) deb = $urandom_range(1, 30);
    else deb = $urandom_range(0, 1) ? 65535 : $urandom_range(31, 65535);
    r = $urandom_range(0, 9);
    if (r == 0) cnt = $urandom_range(0, 1);
    else if (r == 1) cnt = $urandom_range(aicd_pkg::COUNT_LIMIT + 1, 63);
    else if (r < 7) cnt = $urandom_range(aicd_pkg::COUNT_MIN, 8);
    else cnt = $urandom_range(9, aicd_pkg::COUNT_LIMIT);
    r = $urandom_range(0, 9);
    if (r == 0) dev = 0;
    else if (r == 1) dev = $urandom_range(0, 1) ? 127 : $urandom_range(21, 127);
    else dev = $urandom_range(1, 20);
    ana = $urandom_range(0, 4) != 0;
    lvl = (!ana && $urandom_range(0, 2) != 0) ? $urandom_range(0, 1) : $urandom_range(0, 1023);
    analog_first = $urandom_range(0, 1);

    // the analog flag ahead of or behind the deviation write changes what sticks
    if (analog_first) reg_write(aicd_pkg::REG_ANALOG, with_junk(ana, 1));
    if ($urandom_range(0, 3) != 0)
      reg_write(aicd_pkg::REG_DEVIATION, with_junk(dev, aicd_pkg::DEV_W));
    if (!analog_first) reg_write(aicd_pkg::REG_ANALOG, with_junk(ana, 1));
    if ($urandom_range(0, 3) != 0)
      reg_write(aicd_pkg::REG_DEBOUNCE, with_junk(deb, aicd_pkg::DEB_W));
    if ($urandom_range(0, 3) != 0)
      reg_write(aicd_pkg::REG_COUNT, with_junk(cnt, aicd_pkg::CNT_W));
    if ($urandom_range(0, 3) != 0)
      reg_write(aicd_pkg::REG_BUFFERED, with_junk($urandom_range(0, 1), 1));
    if ($urandom_range(0, 3) != 0)
      reg_write(aicd_pkg::REG_FIXED, with_junk($urandom_range(0, 1), 1));
    if ($urandom_range(0, 3) != 0)
      reg_write(aicd_pkg::REG_INIT_LVL, with_junk(lvl, aicd_pkg::LEVEL_W));
    if ($urandom_range(0, 15) == 0) reg_write(REG_SPARE, $urandom());
  endtask

  // drifting level with jitter, bit runs in digital mode, some raw noise
  task automatic random_phase(input int count);
    int base, smp, step, jit, i;
    logic bit_run;
    step = $urandom_range(0, 40);
    jit = $urandom_range(0, 8);
    base = $urandom_range(0, 1023);
    bit_run = $urandom_range(0, 1);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 40) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, 2 * tracker.debounce_ms + 3);
      if ($urandom_range(0, 9) == 0) begin
        smp = $urandom_range(0, 1023);
      end else if (!tracker.analog) begin
        if ($urandom_range(0, 5) == 0) bit_run = !bit_run;
        smp = bit_run;
      end else begin
        if ($urandom_range(0, 15) == 0) base = $urandom_range(0, 1023);
        else base = clamp_code(base + int'($urandom_range(0, 2 * step)) - step);
        smp = clamp_code(base + int'($urandom_range(0, 2 * jit)) - jit);
      end
      send_poll(clock_ms, aicd_pkg::SAMPLE_W'(smp));
    end
  endtask

  initial begin : stimulus
    int sent, n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no averaging, deviation 1, level 0, time extremes
    send_poll(32'd0, 10'd0);
    send_poll(32'd1, 10'd1023);
    send_poll(32'd2, 10'd1023);
    send_poll(32'd3, 10'd0);
    send_poll(32'hFFFF_FFFF, 10'd512);
    send_poll(32'd0, 10'd511);
    drain_events();

    // digital samples; a wide deviation clamps to 1; spare address dropped
    reg_write(aicd_pkg::REG_ANALOG, 32'd0);
    reg_write(aicd_pkg::REG_DEVIATION, 32'd50);
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    reg_write(aicd_pkg::REG_INIT_LVL, 32'd0);
    send_poll(32'd10, 10'd2);
    send_poll(32'd11, 10'd0);
    send_poll(32'd12, 10'd1023);
    send_poll(32'd13, 10'd1);
    drain_events();

    // fixed steps, longest debounce across the time wrap
    reg_write(aicd_pkg::REG_ANALOG, 32'd1);
    reg_write(aicd_pkg::REG_DEVIATION, 32'd100);
    reg_write(aicd_pkg::REG_FIXED, 32'd1);
    reg_write(aicd_pkg::REG_INIT_LVL, 32'd900);
    reg_write(aicd_pkg::REG_DEBOUNCE, 32'd65535);
    send_poll(32'hFFFF_FFF0, 10'd1023);
    send_poll(32'h0000_FFEE, 10'd0);
    send_poll(32'h0000_FFEF, 10'd0);
    drain_events();

    // block of 3 with zero deviation, upper write bits ignored, cut short
    reg_write(aicd_pkg::REG_DEBOUNCE, 32'd0);
    reg_write(aicd_pkg::REG_FIXED, 32'd0);
    reg_write(aicd_pkg::REG_DEVIATION, 32'd0);
    reg_write(aicd_pkg::REG_BUFFERED, 32'd0);
    reg_write(aicd_pkg::REG_COUNT, 32'h0001_0003);
    send_poll(32'd20, 10'd10);
    send_poll(32'd21, 10'd20);
    send_poll(32'd22, 10'd30);
    send_poll(32'd23, 10'd0);
    drain_events();

    // ring mode with a count that stores zero acts without averaging
    reg_write(aicd_pkg::REG_BUFFERED, 32'd1);
    reg_write(aicd_pkg::REG_COUNT, 32'd1);
    send_poll(32'd30, 10'd700);
    drain_events();

    // largest ring
    reg_write(aicd_pkg::REG_COUNT, 32'd60);
    send_poll(32'd31, 10'd1023);
    send_poll(32'd32, 10'd1023);
    send_poll(32'd33, 10'd0);
    drain_events();

    reg_write(aicd_pkg::REG_COUNT, 32'd64);
    reg_write(aicd_pkg::REG_BUFFERED, 32'd0);
    send_poll(32'd34, 10'd5);
    drain_events();

    // random phases, each with its own settings
    sent = 0;
    while (sent < RANDOM_POLLS) begin
      n = $urandom_range(20, 80);
      random_setup();
      random_phase(n);
      drain_events();
      sent += n;
    end

    if (tracker.mismatches == 0 && tracker.expected_events.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
